// ===== sv/bdcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdcg_pkg;

  localparam int COUNT_BITS  = 48;
  localparam int BYTE_BITS   = 48;
  localparam int AMOUNT_BITS = 48;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_BITS   = 3;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_DELIVERED  = 3'd0,
    OP_GRANT      = 3'd1,
    OP_RELEASE_TO = 3'd2,
    OP_RELEASE    = 3'd3,
    OP_ATTACH     = 3'd4,
    OP_DETACH     = 3'd5,
    OP_CANCEL     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ACT_RESUME = 2'd0,
    ACT_PAUSE  = 2'd1,
    ACT_STOP   = 2'd2
  } action_t;

  typedef enum logic {
    CMD_EVAL = 1'b0,
    CMD_STOP = 1'b1
  } cmd_kind_t;

  // Register word index
  localparam logic [ADDR_BITS-3:0] REG_HOLD_AT_START = '0;

  typedef struct packed {
    cmd_kind_t kind;
    cnt_t      credit;
    cnt_t      hold;
    logic      unbounded;
    cnt_t      delivered;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/bdcg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdcg_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_operation,
  input  wire logic [bdcg_pkg::BYTE_BITS-1:0] in_byte_count,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_hold_at_start,
  output logic                               hold_at_start,
  input  wire bdcg_pkg::q_status_t           q_status,
  output bdcg_pkg::push_t                    push
);
  import bdcg_pkg::*;

  logic hold_at_start_r;
  cnt_t credit_r, credit_nxt;
  cnt_t hold_r, hold_nxt;
  logic unb_r, unb_nxt;
  cnt_t deliv_r, deliv_nxt;
  logic term_r, term_nxt;
  logic att_r, att_nxt;
  logic push_req;
  cmd_kind_t kind;
  cnt_t n;
  cnt_t target;
  logic accept;

  generate
    if (COUNT_BITS > BYTE_BITS) begin : g_wide
      assign n = {{(COUNT_BITS-BYTE_BITS){1'b0}}, in_byte_count};
    end else if (COUNT_BITS == BYTE_BITS) begin : g_eq
      assign n = in_byte_count;
    end else begin : g_clamp
      assign n = (|in_byte_count[BYTE_BITS-1:COUNT_BITS]) ? CNT_MAX
                                                          : in_byte_count[COUNT_BITS-1:0];
    end
  endgenerate

  assign in_ready      = !q_status.full;
  assign accept        = in_valid && in_ready;
  assign hold_at_start = hold_at_start_r;
  assign target        = sat_add(deliv_r, n);

  always_comb begin
    credit_nxt = credit_r;
    hold_nxt   = hold_r;
    unb_nxt    = unb_r;
    deliv_nxt  = deliv_r;
    term_nxt   = term_r;
    att_nxt    = att_r;
    push_req   = 1'b0;
    kind       = CMD_EVAL;
    case (op_t'(in_operation))
      OP_DELIVERED: begin
        deliv_nxt = target;
      end
      OP_GRANT: begin
        credit_nxt = sat_add(credit_r, n);
        push_req   = att_r;
      end
      OP_RELEASE_TO: begin
        if (!unb_r) begin
          if (target > hold_r) hold_nxt = target;
          push_req = att_r;
        end
      end
      OP_RELEASE: begin
        unb_nxt  = 1'b1;
        push_req = att_r;
      end
      OP_ATTACH: begin
        push_req = 1'b1;
        if (term_r) begin
          kind = CMD_STOP;
        end else begin
          att_nxt = 1'b1;
        end
      end
      OP_DETACH: begin
        term_nxt = 1'b1;
        att_nxt  = 1'b0;
      end
      OP_CANCEL: begin
        term_nxt = 1'b1;
        att_nxt  = 1'b0;
        push_req = att_r;
        kind     = CMD_STOP;
      end
      default: begin
      end
    endcase
  end

  assign push.valid         = accept && push_req;
  assign push.cmd.kind      = kind;
  assign push.cmd.credit    = credit_nxt;
  assign push.cmd.hold      = hold_nxt;
  assign push.cmd.unbounded = unb_nxt;
  assign push.cmd.delivered = deliv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_at_start_r <= 1'b0;
      credit_r        <= '0;
      hold_r          <= '0;
      unb_r           <= 1'b1;
      deliv_r         <= '0;
      term_r          <= 1'b0;
      att_r           <= 1'b0;
    end else if (cfg_we) begin
      // re-arm the hold state from the new setting
      hold_at_start_r <= cfg_hold_at_start;
      unb_r           <= !cfg_hold_at_start;
      hold_r          <= '0;
    end else if (accept) begin
      credit_r <= credit_nxt;
      hold_r   <= hold_nxt;
      unb_r    <= unb_nxt;
      deliv_r  <= deliv_nxt;
      term_r   <= term_nxt;
      att_r    <= att_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bdcg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdcg_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bdcg_pkg::push_t     push,
  input  wire logic                pop,
  output bdcg_pkg::cmd_t           head,
  output bdcg_pkg::q_status_t      status
);
  import bdcg_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FILL_BITS-1:0] fill_r;
  logic                do_push, do_pop;

  assign status.full  = (fill_r == FILL_BITS'(QUEUE_DEPTH));
  assign status.empty = (fill_r == '0);
  assign do_push      = push.valid && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push.cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/bdcg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdcg_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bdcg_pkg::cmd_t                  head,
  input  wire bdcg_pkg::q_status_t             q_status,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_action,
  output logic [bdcg_pkg::AMOUNT_BITS-1:0]     out_amount
);
  import bdcg_pkg::*;

  logic                   out_valid_r;
  action_t                out_action_r, action_nxt;
  logic [AMOUNT_BITS-1:0] out_amount_r, amount_nxt;
  cnt_t                   allow;
  cnt_t                   rem;
  logic [AMOUNT_BITS-1:0] rem_out;

  // Smaller allowance, an unbounded hold never limits
  assign allow = (!head.unbounded && head.hold < head.credit) ? head.hold : head.credit;
  assign rem   = (allow > head.delivered) ? allow - head.delivered : '0;

  generate
    if (COUNT_BITS > AMOUNT_BITS) begin : g_trunc
      assign rem_out = rem[AMOUNT_BITS-1:0];
    end else if (COUNT_BITS == AMOUNT_BITS) begin : g_eq
      assign rem_out = rem;
    end else begin : g_ext
      assign rem_out = {{(AMOUNT_BITS-COUNT_BITS){1'b0}}, rem};
    end
  endgenerate

  always_comb begin
    if (head.kind == CMD_STOP) begin
      action_nxt = ACT_STOP;
      amount_nxt = '0;
    end else if (rem != '0) begin
      action_nxt = ACT_RESUME;
      amount_nxt = rem_out;
    end else begin
      action_nxt = ACT_PAUSE;
      amount_nxt = '0;
    end
  end

  assign pop        = !q_status.empty && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_amount = out_amount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_action_r <= action_nxt;
      out_amount_r <= amount_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/body_delivery_credit_gate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// in_       input      in_valid / in_ready      in_operation[2:0], in_byte_count[47:0]
// out_      output     out_valid / out_ready    out_action[1:0], out_amount[47:0]
// cfg_      APB slave  psel, penable, pwrite    paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One transaction per cycle while in_ready is high. An event that yields a
// command enters the two-entry command queue at its accepting edge and then
// moves to the output register, raising out_valid, once that register is free.
// Reset is synchronous, active low; the counters clear, hold starts unbounded.
// in_ready drops only while the queue is full: the output register and both
// queue entries hold commands that out_ready has not yet taken.
module body_delivery_credit_gate (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        in_operation,
  input  wire logic [bdcg_pkg::BYTE_BITS-1:0]    in_byte_count,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_action,
  output logic [bdcg_pkg::AMOUNT_BITS-1:0]       out_amount,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [bdcg_pkg::ADDR_BITS-1:0]    cfg_paddr,
  input  wire logic [31:0]                       cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);
  import bdcg_pkg::*;

  logic      cfg_hit;
  logic      cfg_we;
  logic      hold_at_start;
  push_t     push;
  logic      pop;
  cmd_t      head;
  q_status_t q_status;

  // Decode the word address; the low two bits select a byte and are ignored
  assign cfg_hit    = (cfg_paddr[ADDR_BITS-1:2] == REG_HOLD_AT_START);
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? {31'b0, hold_at_start} : 32'b0;

  // Front: apply the event to the gate state and queue any command
  bdcg_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_byte_count     (in_byte_count),
    .cfg_we            (cfg_we),
    .cfg_hold_at_start (cfg_pwdata[0]),
    .hold_at_start     (hold_at_start),
    .q_status          (q_status),
    .push              (push)
  );

  // Hold commands so a stalled output does not stall event intake at once
  bdcg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  // Back: work out the remaining count and drive the output register
  bdcg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_action (out_action),
    .out_amount (out_amount)
  );

endmodule

`default_nettype wire
